[hw/rtl/pps_pkg.sv]
// Package with sizes, codes and controller/datapath interface types of the scheduler.
`timescale 1ns / 1ps

package pps_pkg;

  localparam int MAX_JOBS  = 16;
  localparam int PRIO_BITS = 8;
  localparam int IDX_W     = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W     = $clog2(MAX_JOBS + 1);
  localparam int TIME_W    = 16;
  localparam int BURST_W   = 16;
  localparam int ID_W      = 5;
  localparam int WORD_W    = BURST_W + PRIO_BITS + TIME_W;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RES_OK   = 2'd0,
    RES_RAN  = 2'd1,
    RES_IDLE = 2'd2,
    RES_FULL = 2'd3
  } res_e;

  typedef struct packed {
    logic latch;
    logic exec;
    logic scan_rd;
    logic update;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    cmd_e cmd;
    logic count_zero;
    logic scan_last;
    logic out_busy;
  } stat_t;

endpackage

[hw/rtl/preemptive_priority_scheduler.sv]
// Top level of the preemptive priority scheduler: controller plus datapath.
//
//  channel  dir  tdata (low bit up)                       tuser
//  s_axis   in   burst[15:0] arrival[31:16] prio[39:32]    cmd[1:0]
//  m_axis   out  running_id[4:0] completed[5] now[21:6]
//                all_done[22], zero fill [23]              status[1:0]
//
// A tick beat on loaded entries runs through EXEC, SCAN, LAST, UPD and DONE,
// scanning one entry per cycle through the single read port of the job
// table RAM; clear, load and unused beats go from EXEC straight to DONE, and
// a tick on an empty table goes from EXEC to UPD. Reset clears counters and
// handshake state at once; the table RAM needs no clearing pass. One beat is
// in work at a time; a new beat is taken while the previous result waits on
// m_axis.
`timescale 1ns / 1ps

module preemptive_priority_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // burst, arrival, prio
  input  logic [1:0]  s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // running_id, completed, now, all_done, zero fill
  output logic [1:0]  m_axis_tuser    // status
);

  pps_pkg::ctrl_t ctrl;
  pps_pkg::stat_t stat;

  logic [pps_pkg::ID_W-1:0]   out_id;
  logic                       out_fin;
  logic [pps_pkg::TIME_W-1:0] out_now;
  logic                       out_all;

  pps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  pps_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_cmd_i        (s_axis_tuser),
    .in_burst_i      (s_axis_tdata[15:0]),
    .in_arrival_i    (s_axis_tdata[31:16]),
    .in_prio_i       (s_axis_tdata[39:32]),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_status_o    (m_axis_tuser),
    .out_id_o        (out_id),
    .out_completed_o (out_fin),
    .out_now_o       (out_now),
    .out_all_done_o  (out_all)
  );

  assign m_axis_tdata = {1'b0, out_all, out_now, out_fin, out_id};

endmodule

[hw/rtl/pps_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/pps_ctrl.sv]
// Controller state machine that sequences accept, scan, update and result beats.
`timescale 1ns / 1ps

module pps_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pps_pkg::stat_t stat_i,
  output pps_pkg::ctrl_t ctrl_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_LAST = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.latch = 1'b1;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        ctrl_o.exec = 1'b1;
        if (stat_i.cmd == pps_pkg::CMD_TICK) begin
          state_d = stat_i.count_zero ? S_UPD : S_SCAN;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SCAN: begin
        ctrl_o.scan_rd = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        ctrl_o.update = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          ctrl_o.out_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !stat_i.count_zero)
    else $error("scan with empty table");

  a_exec_after_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.latch |=> (state_q == S_EXEC))
    else $error("accepted beat not executed");

  a_done_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |=> (state_q == S_DONE))
    else $error("update not followed by result");

endmodule

[hw/rtl/pps_dp.sv]
// Datapath: job table RAM, scan compare, counters and result register.
`timescale 1ns / 1ps

module pps_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [1:0]                    in_cmd_i,
  input  logic [pps_pkg::BURST_W-1:0]   in_burst_i,
  input  logic [pps_pkg::TIME_W-1:0]    in_arrival_i,
  input  logic [7:0]                    in_prio_i,
  input  pps_pkg::ctrl_t                ctrl_i,
  output pps_pkg::stat_t                stat_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    out_status_o,
  output logic [pps_pkg::ID_W-1:0]      out_id_o,
  output logic                          out_completed_o,
  output logic [pps_pkg::TIME_W-1:0]    out_now_o,
  output logic                          out_all_done_o
);

  localparam int PB = pps_pkg::PRIO_BITS;
  localparam int TW = pps_pkg::TIME_W;
  localparam int BW = pps_pkg::BURST_W;
  localparam int IW = pps_pkg::IDX_W;
  localparam int CW = pps_pkg::CNT_W;

  pps_pkg::cmd_e        cmd_q;
  logic [BW-1:0]        burst_q;
  logic [TW-1:0]        arrival_q;
  logic [PB-1:0]        prio_q;

  logic [CW-1:0]        entry_q, entry_d;
  logic [CW-1:0]        done_q, done_d;
  logic [TW-1:0]        time_q, time_d;
  logic [IW-1:0]        scan_q, scan_d;
  logic                 rd_valid_q;
  logic [IW-1:0]        rd_idx_q;
  logic                 found_q, found_d;
  logic [IW-1:0]        best_idx_q, best_idx_d;
  logic [TW-1:0]        best_arr_q, best_arr_d;
  logic [PB-1:0]        best_prio_q, best_prio_d;
  logic [BW-1:0]        best_rem_q, best_rem_d;

  pps_pkg::res_e        res_status_q, res_status_d;
  logic [pps_pkg::ID_W-1:0] res_id_q, res_id_d;
  logic                 res_fin_q, res_fin_d;

  logic                 out_valid_q;
  pps_pkg::res_e        out_status_q;
  logic [pps_pkg::ID_W-1:0] out_id_q;
  logic                 out_fin_q;
  logic [TW-1:0]        out_now_q;
  logic                 out_all_q;

  logic                 we;
  logic [IW-1:0]        waddr;
  logic [pps_pkg::WORD_W-1:0] wdata;
  logic [pps_pkg::WORD_W-1:0] rdata;
  logic [TW-1:0]        rd_arr;
  logic [PB-1:0]        rd_prio;
  logic [BW-1:0]        rd_rem;
  logic                 rd_take;
  logic                 full;

  assign full    = (entry_q == CW'(pps_pkg::MAX_JOBS));
  assign rd_arr  = rdata[TW-1:0];
  assign rd_prio = rdata[TW+PB-1:TW];
  assign rd_rem  = rdata[pps_pkg::WORD_W-1:TW+PB];
  assign rd_take = rd_valid_q && (rd_arr <= time_q) && (rd_rem != '0)
                   && (!found_q || (rd_prio < best_prio_q));

  always_comb begin
    entry_d      = entry_q;
    done_d       = done_q;
    time_d       = time_q;
    scan_d       = scan_q;
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_arr_d   = best_arr_q;
    best_prio_d  = best_prio_q;
    best_rem_d   = best_rem_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_fin_d    = res_fin_q;
    we           = 1'b0;
    waddr        = entry_q[IW-1:0];
    wdata        = {burst_q, prio_q, arrival_q};

    if (ctrl_i.exec) begin
      res_status_d = pps_pkg::RES_OK;
      res_id_d     = '0;
      res_fin_d    = 1'b0;
      scan_d       = '0;
      found_d      = 1'b0;
      case (cmd_q)
        pps_pkg::CMD_CLEAR: begin
          entry_d = '0;
          done_d  = '0;
          time_d  = '0;
        end
        pps_pkg::CMD_LOAD: begin
          if (full) begin
            res_status_d = pps_pkg::RES_FULL;
          end else begin
            we      = 1'b1;
            entry_d = entry_q + CW'(1);
            if (burst_q == '0) begin
              done_d = done_q + CW'(1);
            end
          end
        end
        default: ;
      endcase
    end

    if (ctrl_i.scan_rd) begin
      scan_d = scan_q + IW'(1);
    end

    if (rd_take) begin
      found_d     = 1'b1;
      best_idx_d  = rd_idx_q;
      best_arr_d  = rd_arr;
      best_prio_d = rd_prio;
      best_rem_d  = rd_rem;
    end

    if (ctrl_i.update) begin
      if (time_q != '1) begin
        time_d = time_q + TW'(1);
      end
      if (found_q) begin
        we           = 1'b1;
        waddr        = best_idx_q;
        wdata        = {best_rem_q - BW'(1), best_prio_q, best_arr_q};
        res_status_d = pps_pkg::RES_RAN;
        res_id_d     = pps_pkg::ID_W'(best_idx_q) + pps_pkg::ID_W'(1);
        res_fin_d    = (best_rem_q == BW'(1));
        if (best_rem_q == BW'(1)) begin
          done_d = done_q + CW'(1);
        end
      end else begin
        res_status_d = pps_pkg::RES_IDLE;
        res_id_d     = '0;
        res_fin_d    = 1'b0;
      end
    end
  end

  pps_ram #(
    .WIDTH (pps_pkg::WORD_W),
    .DEPTH (pps_pkg::MAX_JOBS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (ctrl_i.scan_rd),
    .raddr_i (scan_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      cmd_q     <= pps_pkg::cmd_e'(in_cmd_i);
      burst_q   <= in_burst_i;
      arrival_q <= in_arrival_i;
      prio_q    <= PB'(in_prio_i);
    end
    scan_q       <= scan_d;
    rd_idx_q     <= scan_q;
    best_idx_q   <= best_idx_d;
    best_arr_q   <= best_arr_d;
    best_prio_q  <= best_prio_d;
    best_rem_q   <= best_rem_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_fin_q    <= res_fin_d;
    if (ctrl_i.out_load) begin
      out_status_q <= res_status_q;
      out_id_q     <= res_id_q;
      out_fin_q    <= res_fin_q;
      out_now_q    <= time_q;
      out_all_q    <= (done_q == entry_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q     <= '0;
      done_q      <= '0;
      time_q      <= '0;
      found_q     <= 1'b0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      entry_q    <= entry_d;
      done_q     <= done_d;
      time_q     <= time_d;
      found_q    <= found_d;
      rd_valid_q <= ctrl_i.scan_rd;
      if (ctrl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.cmd        = cmd_q;
  assign stat_o.count_zero = (entry_q == '0);
  assign stat_o.scan_last  = (CW'(scan_q) == entry_q - CW'(1));
  assign stat_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign out_status_o    = out_status_q;
  assign out_id_o        = out_id_q;
  assign out_completed_o = out_fin_q;
  assign out_now_o       = out_now_q;
  assign out_all_done_o  = out_all_q;

  a_entry_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_q <= CW'(pps_pkg::MAX_JOBS))
    else $error("entry count beyond table size");

  a_done_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q <= entry_q)
    else $error("done count beyond entry count");

  a_scan_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.scan_rd |-> (CW'(scan_q) < entry_q))
    else $error("scan read outside loaded entries");

  a_best_has_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.update && found_q) |-> (best_rem_q != '0))
    else $error("selected job has no time left");

endmodule
